@@ sv/mwm_pkg.sv @@
// Shared widths, register indexes and inter-stage types for the mecanum wheel mixer.
// No dependencies; every other file of the block refers to it by scoped names.
package mwm_pkg;

  localparam int unsigned LANES     = 4;   // wheels
  localparam int unsigned SPEED_W   = 16;  // Q4.12 speeds and wheel results
  localparam int unsigned ARM_W     = 16;  // Q2.14 rotation arms
  localparam int unsigned LIMIT_W   = 15;  // Q3.12 unsigned speed limit
  localparam int unsigned CFG_W     = 16;  // widest register
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = SPEED_W + ARM_W;     // rate * arm, Q6.26
  localparam int unsigned ARM_FRAC  = 14;
  localparam int unsigned SUM_W     = 19;  // |w| <= 2^17 needs sign plus 18 bits
  localparam int unsigned MAG_W     = SUM_W - 1;
  localparam int unsigned QUO_W     = LIMIT_W;              // scaled magnitude <= limit
  localparam int unsigned REM_W     = MAG_W - 1;            // remainder < max <= 2^17
  localparam int unsigned NUM_W     = REM_W + QUO_W;        // |w|*L + max/2 < 2^32

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (ARM_FRAC - 1));

  localparam logic signed [ARM_W-1:0] FRONT_ARM_RST = ARM_W'(4096);
  localparam logic signed [ARM_W-1:0] REAR_ARM_RST  = ARM_W'(4096);
  localparam logic [LIMIT_W-1:0]      LIMIT_RST     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_ARM   = 2'd0,
    REG_REAR_ARM    = 2'd1,
    REG_SPEED_LIMIT = 2'd2
  } cfg_reg_e;

  // raw wheel sums, each a signed SUM_W value
  typedef struct packed {
    logic [LANES-1:0][SUM_W-1:0] sum;
  } mix_out_t;

  // normalization results ahead of the divider
  typedef struct packed {
    logic                          scaled;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][SPEED_W-1:0] w16;
    logic [LANES-1:0][NUM_W-1:0]   num;
    logic [MAG_W-1:0]              max_mag;
  } norm_out_t;

  typedef struct packed {
    logic                          scaled;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][SPEED_W-1:0] w16;
    logic [LANES-1:0][QUO_W-1:0]   quo;
  } div_out_t;

  typedef struct packed {
    logic                          scaled;
    logic [LANES-1:0][SPEED_W-1:0] wheel;
  } out_item_t;

endpackage

@@ sv/mwm_mix.sv @@
// Mixing front end: rotation products, then the four raw mecanum wheel sums.
// Two register stages; uses mwm_pkg.
module mwm_mix (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic signed [mwm_pkg::SPEED_W-1:0]    forward_speed_i,
  input  logic signed [mwm_pkg::SPEED_W-1:0]    lateral_speed_i,
  input  logic signed [mwm_pkg::SPEED_W-1:0]    turn_rate_i,
  input  logic signed [mwm_pkg::ARM_W-1:0]      front_arm_i,
  input  logic signed [mwm_pkg::ARM_W-1:0]      rear_arm_i,
  output logic                                  valid_o,
  output mwm_pkg::mix_out_t                     data_o
);

  logic                                 v1_q, v2_q;
  logic signed [mwm_pkg::SPEED_W-1:0]   vx1_q, vy1_q;
  logic signed [mwm_pkg::PROD_W-1:0]    pf1_q, pr1_q;
  logic signed [mwm_pkg::PROD_W-1:0]    pf1_d, pr1_d;
  logic signed [mwm_pkg::PROD_W-1:0]    rf_full, rr_full;
  logic signed [mwm_pkg::SUM_W-1:0]     rf, rr, vx_e, vy_e;
  mwm_pkg::mix_out_t                    sum2_d, sum2_q;

  always_comb begin
    pf1_d = mwm_pkg::PROD_W'(turn_rate_i) * mwm_pkg::PROD_W'(front_arm_i);
    pr1_d = mwm_pkg::PROD_W'(turn_rate_i) * mwm_pkg::PROD_W'(rear_arm_i);
  end

  // round Q6.26 to Q4.12, ties toward plus infinity
  always_comb begin
    rf_full = pf1_q + mwm_pkg::ROUND_HALF;
    rr_full = pr1_q + mwm_pkg::ROUND_HALF;
    rf      = mwm_pkg::SUM_W'(rf_full >>> mwm_pkg::ARM_FRAC);
    rr      = mwm_pkg::SUM_W'(rr_full >>> mwm_pkg::ARM_FRAC);
    vx_e    = mwm_pkg::SUM_W'(vx1_q);
    vy_e    = mwm_pkg::SUM_W'(vy1_q);
    sum2_d.sum[0] = -vx_e - vy_e + rf;
    sum2_d.sum[1] =  vx_e - vy_e + rf;
    sum2_d.sum[2] =  vx_e + vy_e + rr;
    sum2_d.sum[3] = -vx_e + vy_e + rr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx1_q  <= forward_speed_i;
      vy1_q  <= lateral_speed_i;
      pf1_q  <= pf1_d;
      pr1_q  <= pr1_d;
      sum2_q <= sum2_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = sum2_q;

endmodule

@@ sv/mwm_norm.sv @@
// Normalization: magnitudes, largest magnitude, limit products and rounded numerators.
// Four register stages; uses mwm_pkg.
module mwm_norm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  mwm_pkg::mix_out_t                 data_i,
  input  logic [mwm_pkg::LIMIT_W-1:0]       limit_i,
  output logic                              valid_o,
  output mwm_pkg::norm_out_t                data_o
);

  localparam int unsigned L = mwm_pkg::LANES;

  logic [3:0] v_q;

  // stage 3: magnitudes
  logic [L-1:0][mwm_pkg::MAG_W-1:0]   mag3_d, mag3_q;
  logic [L-1:0]                       neg3_d, neg3_q;
  logic [L-1:0][mwm_pkg::SPEED_W-1:0] w3_d, w3_q;
  // stage 4: largest magnitude
  logic [mwm_pkg::MAG_W-1:0]          max_a, max_b, max4_d, max4_q;
  logic [L-1:0][mwm_pkg::MAG_W-1:0]   mag4_q;
  logic [L-1:0]                       neg4_q;
  logic [L-1:0][mwm_pkg::SPEED_W-1:0] w4_q;
  // stage 5: products against the limit
  logic [L-1:0][mwm_pkg::NUM_W-1:0]   prod5_d, prod5_q;
  logic                               sc5_d, sc5_q;
  logic [mwm_pkg::MAG_W-1:0]          max5_q;
  logic [L-1:0]                       neg5_q;
  logic [L-1:0][mwm_pkg::SPEED_W-1:0] w5_q;
  // stage 6: add half the divisor for round to nearest
  mwm_pkg::norm_out_t                 s6_d, s6_q;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      logic signed [mwm_pkg::SUM_W-1:0] s;
      logic signed [mwm_pkg::SUM_W-1:0] ns;
      s         = $signed(data_i.sum[i]);
      ns        = -s;
      neg3_d[i] = s[mwm_pkg::SUM_W-1];
      mag3_d[i] = neg3_d[i] ? ns[mwm_pkg::MAG_W-1:0] : s[mwm_pkg::MAG_W-1:0];
      w3_d[i]   = s[mwm_pkg::SPEED_W-1:0];
    end
  end

  always_comb begin
    max_a  = (mag3_q[0] > mag3_q[1]) ? mag3_q[0] : mag3_q[1];
    max_b  = (mag3_q[2] > mag3_q[3]) ? mag3_q[2] : mag3_q[3];
    max4_d = (max_a > max_b) ? max_a : max_b;
  end

  always_comb begin
    for (int i = 0; i < L; i++) begin
      prod5_d[i] = mwm_pkg::NUM_W'(mag4_q[i]) * mwm_pkg::NUM_W'(limit_i);
    end
    sc5_d = max4_q > mwm_pkg::MAG_W'(limit_i);
  end

  always_comb begin
    s6_d.scaled  = sc5_q;
    s6_d.neg     = neg5_q;
    s6_d.w16     = w5_q;
    s6_d.max_mag = max5_q;
    for (int i = 0; i < L; i++) begin
      s6_d.num[i] = prod5_q[i] + mwm_pkg::NUM_W'(max5_q >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag3_q  <= mag3_d;
      neg3_q  <= neg3_d;
      w3_q    <= w3_d;
      max4_q  <= max4_d;
      mag4_q  <= mag3_q;
      neg4_q  <= neg3_q;
      w4_q    <= w3_q;
      prod5_q <= prod5_d;
      sc5_q   <= sc5_d;
      max5_q  <= max4_q;
      neg5_q  <= neg4_q;
      w5_q    <= w4_q;
      s6_q    <= s6_d;
    end
  end

  assign valid_o = v_q[3];
  assign data_o  = s6_q;

endmodule

@@ sv/mwm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, four lanes sharing one divisor.
// QUO_W register stages; uses mwm_pkg.
module mwm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  mwm_pkg::norm_out_t    data_i,
  output logic                  valid_o,
  output mwm_pkg::div_out_t     data_o
);

  localparam int unsigned L  = mwm_pkg::LANES;
  localparam int unsigned QW = mwm_pkg::QUO_W;
  localparam int unsigned RW = mwm_pkg::REM_W;

  typedef struct packed {
    logic                                 scaled;
    logic [L-1:0]                         neg;
    logic [L-1:0][mwm_pkg::SPEED_W-1:0]   w16;
    logic [mwm_pkg::MAG_W-1:0]            dvs;
    logic [L-1:0][RW-1:0]                 rem;
    logic [L-1:0][QW-1:0]                 low;
    logic [L-1:0][QW-1:0]                 quo;
  } div_stage_t;

  div_stage_t       stg_init;
  div_stage_t       stg_q [QW];
  logic [QW-1:0]    v_q;

  // top bits of the numerator are already below the divisor: quotient fits QW bits
  always_comb begin
    stg_init.scaled = data_i.scaled;
    stg_init.neg    = data_i.neg;
    stg_init.w16    = data_i.w16;
    stg_init.dvs    = data_i.max_mag;
    for (int i = 0; i < L; i++) begin
      stg_init.rem[i] = data_i.num[i][mwm_pkg::NUM_W-1:QW];
      stg_init.low[i] = data_i.num[i][QW-1:0];
      stg_init.quo[i] = '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    div_stage_t src;
    div_stage_t nxt;

    if (j == 0) begin : g_first
      assign src = stg_init;
    end else begin : g_rest
      assign src = stg_q[j-1];
    end

    always_comb begin
      nxt = src;
      for (int i = 0; i < L; i++) begin
        logic [RW:0] trial;
        logic [RW:0] diff;
        logic        ge;
        trial      = {src.rem[i], src.low[i][QW-1]};
        diff       = trial - src.dvs;
        ge         = trial >= src.dvs;
        nxt.rem[i] = ge ? diff[RW-1:0] : trial[RW-1:0];
        nxt.low[i] = {src.low[i][QW-2:0], 1'b0};
        nxt.quo[i] = {src.quo[i][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QW-2:0], valid_i};
    end
  end

  assign valid_o       = v_q[QW-1];
  assign data_o.scaled = stg_q[QW-1].scaled;
  assign data_o.neg    = stg_q[QW-1].neg;
  assign data_o.w16    = stg_q[QW-1].w16;
  assign data_o.quo    = stg_q[QW-1].quo;

endmodule

@@ sv/mwm_ofifo.sv @@
// Two-entry output queue that parts the pipeline from the result channel.
// Uses mwm_pkg for the result type.
module mwm_ofifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mwm_pkg::out_item_t    push_data_i,
  input  logic                  pop_i,
  output logic                  pop_valid_o,
  output mwm_pkg::out_item_t    pop_data_o,
  output logic [1:0]            count_o
);

  mwm_pkg::out_item_t mem_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q, cnt_d;
  logic               do_pop;

  assign do_pop = pop_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_valid_o = cnt_q != 2'd0;
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;

endmodule

@@ sv/mecanum_wheel_mixer_top.sv @@
// Mecanum wheel mixer: top level with configuration registers, pipeline and output queue.
// Depends on mwm_pkg, mwm_mix, mwm_norm, mwm_div and mwm_ofifo.
//
//   channel   direction  handshake                 payload
//   s_axis    in         tvalid/tready             tdata: forward, lateral, turn rate
//   m_axis    out        tvalid/tready             tdata: four wheels, tuser: was_scaled
//   cfg       in         cfg_we_i, no wait         cfg_addr_i, cfg_wdata_i
//
// One request per cycle sustained while the output queue is not full; each request passes
// through 2 mixing, 4 normalization and 15 divider stages, then the output queue.
// Reset clears valid bits, queue pointers and the registers to their defaults.
// All stages advance together while the two-entry output queue is not full; when it is,
// the pipeline holds and s_axis_tready drops, from registered state only.
module mecanum_wheel_mixer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] forward_speed, [31:16] lateral_speed, [47:32] turn_rate
  input  logic [47:0]                       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] wheel_front_left, [31:16] wheel_front_right,
  // [47:32] wheel_rear_right, [63:48] wheel_rear_left
  output logic [63:0]                       m_axis_tdata,
  // [0] was_scaled
  output logic                              m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [mwm_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned SW = mwm_pkg::SPEED_W;

  logic signed [mwm_pkg::ARM_W-1:0]  front_arm_q, rear_arm_q;
  logic [mwm_pkg::LIMIT_W-1:0]       limit_q;

  logic                  pipe_en;
  logic                  mix_valid, norm_valid, div_valid;
  mwm_pkg::mix_out_t     mix_data;
  mwm_pkg::norm_out_t    norm_data;
  mwm_pkg::div_out_t     div_data;
  mwm_pkg::out_item_t    res_item, q_item;
  logic [1:0]            q_count;
  logic                  push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_arm_q <= mwm_pkg::FRONT_ARM_RST;
      rear_arm_q  <= mwm_pkg::REAR_ARM_RST;
      limit_q     <= mwm_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (mwm_pkg::cfg_reg_e'(cfg_addr_i))
        mwm_pkg::REG_FRONT_ARM:   front_arm_q <= cfg_wdata_i;
        mwm_pkg::REG_REAR_ARM:    rear_arm_q  <= cfg_wdata_i;
        mwm_pkg::REG_SPEED_LIMIT: limit_q     <= cfg_wdata_i[mwm_pkg::LIMIT_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // hold every stage while the queue is full
  assign pipe_en       = q_count != 2'd2;
  assign s_axis_tready = pipe_en;

  mwm_mix u_mix (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (pipe_en),
    .valid_i         (s_axis_tvalid),
    .forward_speed_i (s_axis_tdata[SW-1:0]),
    .lateral_speed_i (s_axis_tdata[2*SW-1:SW]),
    .turn_rate_i     (s_axis_tdata[3*SW-1:2*SW]),
    .front_arm_i     (front_arm_q),
    .rear_arm_i      (rear_arm_q),
    .valid_o         (mix_valid),
    .data_o          (mix_data)
  );

  mwm_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (mix_valid),
    .data_i  (mix_data),
    .limit_i (limit_q),
    .valid_o (norm_valid),
    .data_o  (norm_data)
  );

  mwm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (norm_valid),
    .data_i  (norm_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  // reapply the sign to scaled magnitudes; pass unscaled sums through
  always_comb begin
    res_item.scaled = div_data.scaled;
    for (int i = 0; i < mwm_pkg::LANES; i++) begin
      logic [SW-1:0] q16;
      q16 = SW'(div_data.quo[i]);
      if (div_data.scaled) begin
        res_item.wheel[i] = div_data.neg[i] ? (~q16 + SW'(1)) : q16;
      end else begin
        res_item.wheel[i] = div_data.w16[i];
      end
    end
  end

  assign push = div_valid && pipe_en;

  mwm_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res_item),
    .pop_i       (m_axis_tready),
    .pop_valid_o (m_axis_tvalid),
    .pop_data_o  (q_item),
    .count_o     (q_count)
  );

  assign m_axis_tdata = q_item.wheel;
  assign m_axis_tuser = q_item.scaled;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count != 2'd3)
    else $error("output queue count out of range");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(div_valid))
    else $error("pipeline moved while stalled");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> m_axis_tvalid)
    else $error("pushed result not presented");

  a_scaled_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_valid && norm_data.scaled |-> norm_data.max_mag != '0)
    else $error("scaling requested with zero divisor");

endmodule

@@ sim/tb_mecanum_wheel_mixer_top.sv @@
// Self-checking bench for mecanum_wheel_mixer_top: a directed table, then randomized commands
// under several register settings, checked against typed expected wheels or a wheel mixing model kept in the bench.
// Depends on mwm_pkg and the mixer RTL.
module tb_mecanum_wheel_mixer_top;

  localparam int DIR_ROWS     = 25;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 90;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 1000;

  // index with no register behind it; writes there must be dropped
  localparam logic [mwm_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [mwm_pkg::SPEED_W-1:0] fl;
    logic [mwm_pkg::SPEED_W-1:0] fr;
    logic [mwm_pkg::SPEED_W-1:0] rr;
    logic [mwm_pkg::SPEED_W-1:0] rl;
    logic                        scaled;
  } wheel_set_t;

  typedef struct packed {
    row_kind_e                     kind;
    logic [mwm_pkg::CFG_IDX_W-1:0] idx;
    logic [mwm_pkg::CFG_W-1:0]     val;
    logic [mwm_pkg::SPEED_W-1:0]   vx;
    logic [mwm_pkg::SPEED_W-1:0]   vy;
    logic [mwm_pkg::SPEED_W-1:0]   wz;
    logic                          has_want;
    wheel_set_t                    want;
  } stim_row_t;

  localparam wheel_set_t NO_WANT = '0;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [47:0]                   s_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [63:0]                   m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_we_i;
  logic [mwm_pkg::CFG_IDX_W-1:0] cfg_addr_i;
  logic [mwm_pkg::CFG_W-1:0]     cfg_wdata_i;

  // register copies used for prediction
  longint     front_arm_q = 4096;
  longint     rear_arm_q  = 4096;
  longint     limit_q     = 32767;

  wheel_set_t wheel_sets_due[$];
  int         mismatch_count = 0;
  int         results_seen   = 0;
  int         idle_level     = 0;  // chance of an input gap or a stall burst, out of 16
  int         stall_left     = 0;
  int         quiet_cycles   = 0;

  // columns: kind, register, value, forward, lateral, turn, typed, expected wheels
  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b1,
      '{16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 1'b0}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1,
      '{16'h8001, 16'h7FFF, 16'h7FFF, 16'h8001, 1'b0}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b1,
      '{16'h7FFF, 16'h8001, 16'h8001, 16'h7FFF, 1'b1}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1,
      '{16'h7FFF, 16'h7FFF, 16'h8001, 16'h8001, 1'b1}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1,
      '{16'hE000, 16'hE000, 16'hE000, 16'hE000, 1'b0}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b1,
      '{16'h2000, 16'h2000, 16'h2000, 16'h2000, 1'b0}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 1'b0, NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, NO_WANT},
    '{ROW_CFG, mwm_pkg::REG_FRONT_ARM, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_WANT},
    '{ROW_CFG, mwm_pkg::REG_REAR_ARM, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_WANT},
    '{ROW_CFG, REG_SPARE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, NO_WANT},
    // zero limit: any motion collapses to zero and is flagged as scaled
    '{ROW_CFG, mwm_pkg::REG_SPEED_LIMIT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
      NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
    // bit 15 of the limit write must be dropped
    '{ROW_CFG, mwm_pkg::REG_SPEED_LIMIT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0,
      NO_WANT},
    '{ROW_CFG, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_WANT},
    '{ROW_CFG, mwm_pkg::REG_REAR_ARM, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, NO_WANT},
    '{ROW_CMD, mwm_pkg::REG_FRONT_ARM, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1,
      '{16'h8001, 16'h0000, 16'h7FFF, 16'h0000, 1'b1}}
  };

  mecanum_wheel_mixer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Wheel speeds for one command under the current register copies.
  function automatic wheel_set_t mix_wheels(logic [mwm_pkg::SPEED_W-1:0] vx,
                                            logic [mwm_pkg::SPEED_W-1:0] vy,
                                            logic [mwm_pkg::SPEED_W-1:0] wz);
    longint     fx;
    longint     fy;
    longint     rot_f;
    longint     rot_r;
    longint     w [4];
    longint     mag;
    longint     peak;
    wheel_set_t res;
    fx    = longint'($signed(vx));
    fy    = longint'($signed(vy));
    // Q6.26 product back to Q4.12, round half up
    rot_f = (longint'($signed(wz)) * front_arm_q + 8192) >>> 14;
    rot_r = (longint'($signed(wz)) * rear_arm_q + 8192) >>> 14;
    w[0]  = -fx - fy + rot_f;
    w[1]  =  fx - fy + rot_f;
    w[2]  =  fx + fy + rot_r;
    w[3]  = -fx + fy + rot_r;
    peak  = 0;
    for (int i = 0; i < 4; i++) begin
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > peak) peak = mag;
    end
    res.scaled = (peak > limit_q);
    if (res.scaled) begin
      for (int i = 0; i < 4; i++) begin
        mag  = (w[i] < 0) ? -w[i] : w[i];
        mag  = (mag * limit_q + peak / 2) / peak;
        w[i] = (w[i] < 0) ? -mag : mag;
      end
    end
    res.fl = 16'(w[0]);
    res.fr = 16'(w[1]);
    res.rr = 16'(w[2]);
    res.rl = 16'(w[3]);
    return res;
  endfunction

  function automatic logic [mwm_pkg::SPEED_W-1:0] rand_speed();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 511) - 256);
      3:       return 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [mwm_pkg::CFG_W-1:0] rand_arm();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 8191));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [mwm_pkg::CFG_W-1:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_error(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Called just after a falling edge; returns just after the falling edge past acceptance.
  task automatic send_command(input logic [mwm_pkg::SPEED_W-1:0] vx,
                              input logic [mwm_pkg::SPEED_W-1:0] vy,
                              input logic [mwm_pkg::SPEED_W-1:0] wz, input logic has_want,
                              input wheel_set_t typed_want);
    int gap;
    if (idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {wz, vy, vx};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    wheel_sets_due.push_back(has_want ? typed_want : mix_wheels(vx, vy, wz));
    @(negedge clk_i);
  endtask

  // Drain the pipeline, then write one register and mirror it.
  task automatic write_register(input logic [mwm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mwm_pkg::CFG_W-1:0] val);
    s_axis_tvalid = 1'b0;
    while (wheel_sets_due.size() != 0) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      mwm_pkg::REG_FRONT_ARM:   front_arm_q = longint'($signed(val));
      mwm_pkg::REG_REAR_ARM:    rear_arm_q  = longint'($signed(val));
      mwm_pkg::REG_SPEED_LIMIT: limit_q     = longint'(val[mwm_pkg::LIMIT_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = mwm_pkg::REG_FRONT_ARM;
    cfg_wdata_i   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    idle_level = 3;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].kind == ROW_CFG) begin
        write_register(dir_table[r].idx, dir_table[r].val);
      end else begin
        send_command(dir_table[r].vx, dir_table[r].vy, dir_table[r].wz,
                     dir_table[r].has_want, dir_table[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // last phase runs with both sides always ready
      idle_level = (p == PHASES - 1) ? 0 : int'($urandom_range(0, 6));
      write_register(mwm_pkg::REG_FRONT_ARM, rand_arm());
      write_register(mwm_pkg::REG_REAR_ARM, rand_arm());
      write_register(mwm_pkg::REG_SPEED_LIMIT, rand_limit());
      write_register(REG_SPARE, 16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_command(rand_speed(), rand_speed(), rand_speed(), 1'b0, NO_WANT);
      end
    end

    s_axis_tvalid = 1'b0;
    while (wheel_sets_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side backpressure: random stall bursts, none when idle_level is zero.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left    = stall_left - 1;
    end else if (idle_level != 0 && $urandom_range(0, 15) < idle_level) begin
      m_axis_tready = 1'b0;
      stall_left    = $urandom_range(1, 19) - 1;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    wheel_set_t got;
    wheel_set_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
              m_axis_tdata[63:48], m_axis_tuser};
      if (wheel_sets_due.size() == 0) begin
        report_error($sformatf("result %0d arrived with no request outstanding", results_seen));
      end else begin
        want = wheel_sets_due.pop_front();
        if (got.fl !== want.fl)
          report_error($sformatf("result %0d wheel_front_left got %0d want %0d",
                                 results_seen, $signed(got.fl), $signed(want.fl)));
        if (got.fr !== want.fr)
          report_error($sformatf("result %0d wheel_front_right got %0d want %0d",
                                 results_seen, $signed(got.fr), $signed(want.fr)));
        if (got.rr !== want.rr)
          report_error($sformatf("result %0d wheel_rear_right got %0d want %0d",
                                 results_seen, $signed(got.rr), $signed(want.rr)));
        if (got.rl !== want.rl)
          report_error($sformatf("result %0d wheel_rear_left got %0d want %0d",
                                 results_seen, $signed(got.rl), $signed(want.rl)));
        if (got.scaled !== want.scaled)
          report_error($sformatf("result %0d was_scaled got %0b want %0b",
                                 results_seen, got.scaled, want.scaled));
      end
      results_seen++;
    end
  end

  // Abort when nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
